// ===== src/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// Depends on nothing; every other file of the block imports it.
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int INDEX_W = 11;  // cell_index width
    localparam int POS_W   = 11;  // cursor_position width

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_BLANK   = 8'h20;
    localparam logic [7:0] ATTR_RESET   = 8'h07;
    localparam int         TAB_STEP     = 4;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } command_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         char_code;
        logic [INDEX_W-1:0] cell_index;
    } tcw_in_t;

    typedef struct packed {
        logic [POS_W-1:0] cursor_position;
        logic [7:0]       cell_char;
        logic [7:0]       cell_attribute;
    } tcw_out_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_COPY,
        ST_DRAIN,
        ST_BLANK,
        ST_CLEAR,
        ST_DONE
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic put_step;
        logic rd_issue;
        logic copy_step;
        logic blank_step;
        logic blank_reset_attr;
        logic sweep_zero;
        logic sweep_lastrow;
        logic home;
        logic load_out;
    } tcw_cmd_t;

    // Datapath to controller
    typedef struct packed {
        command_t op;
        logic     put_scroll;
        logic     sweep_last;
        logic     copy_last;
    } tcw_stat_t;

endpackage

// ===== src/text_console_writer.sv =====
// Text console writer: COLUMNS x ROWS character store with cursor, put/clear/read commands.
// Put, read and unused commands pass through the accept, execute and result-load steps;
// a put that scrolls adds a copy and blanking sweep, a clear adds a blanking sweep of the store.
// One item at a time: a new command is accepted only once the last one's result is loaded.
// Reset: synchronous, active low; a clearing pass over every cell after reset
// blanks the store with attribute 7 while s_ready stays low; cfg writes are taken throughout.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic              aclk,
    input  logic              aresetn,
    // command input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  tcw_pkg::tcw_in_t  s_data,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output tcw_pkg::tcw_out_t m_data,
    // attribute register write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data
);
    import tcw_pkg::*;

    tcw_cmd_t  cmd;
    tcw_stat_t stat;

    // The attribute register takes every transfer; writes are expected only while idle.
    assign cfg_ready = 1'b1;

    // Controller: walks each command through exec, optional scroll/clear sweep, and result.
    tcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: screen store (one write, one registered read per cycle), cursor,
    // sweep counter for scroll copy and blanking, and the result register.
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_data    (m_data)
    );

endmodule

// ===== src/tcw_datapath.sv =====
// Datapath of the text console writer: screen store, cursor, sweep counter, result register.
// Depends on tcw_pkg; driven by tcw_ctrl through tcw_cmd_t.
module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tcw_pkg::tcw_in_t  s_data,
    input  logic              cfg_valid,
    input  logic [7:0]        cfg_data,
    input  tcw_pkg::tcw_cmd_t cmd,
    output tcw_pkg::tcw_stat_t stat,
    output tcw_pkg::tcw_out_t m_data
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int PW    = ((AW > INDEX_W) ? AW : INDEX_W) + 1;

    logic [15:0]   mem [CELLS];

    tcw_in_t       in_reg;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic          wb_pend_reg;
    logic [AW-1:0] wb_addr_reg;
    logic [15:0]   rd_data_reg;
    logic          rd_ok_reg;
    logic [7:0]    attr_reg;
    tcw_out_t      out_reg, out_next;

    logic          is_nl, is_tab, is_write, tab_fits, col_last, row_last, line_feed;
    logic [CW:0]   col_ext;
    logic [PW-1:0] pos_wide, idx_wide;
    logic          idx_ok;
    logic          we, re;
    logic [AW-1:0] wa, ra;
    logic [15:0]   wd;
    logic [7:0]    blank_attr;

    // Put decode
    always_comb begin
        is_nl     = (in_reg.char_code == CHAR_NEWLINE);
        is_tab    = (in_reg.char_code == CHAR_TAB);
        is_write  = !is_nl && !is_tab;
        col_ext   = {1'b0, col_reg};
        tab_fits  = (col_ext + (CW+1)'(TAB_STEP)) < (CW+1)'(COLUMNS - 1);
        col_last  = (col_reg == CW'(COLUMNS - 1));
        row_last  = (row_reg == RW'(ROWS - 1));
        line_feed = is_nl || (is_tab && !tab_fits) || (is_write && col_last);
        pos_wide  = PW'(row_reg) * PW'(COLUMNS) + PW'(col_reg);
        idx_wide  = PW'(in_reg.cell_index);
        idx_ok    = (idx_wide < PW'(CELLS));
    end

    // Cursor
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.home) begin
            col_next = '0;
            row_next = '0;
        end else if (cmd.put_step) begin
            if (line_feed) begin
                col_next = '0;
                if (!row_last) begin
                    row_next = row_reg + RW'(1);
                end
            end else if (is_tab) begin
                col_next = col_reg + CW'(TAB_STEP);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    // Sweep counter
    always_comb begin
        sweep_next = sweep_reg;
        if (cmd.sweep_zero) begin
            sweep_next = '0;
        end else if (cmd.sweep_lastrow) begin
            sweep_next = AW'(CELLS - COLUMNS);
        end else if (cmd.blank_step || cmd.copy_step) begin
            sweep_next = sweep_reg + AW'(1);
        end
    end

    // Store port selection; a pending scroll write-back has the write port first
    always_comb begin
        blank_attr = cmd.blank_reset_attr ? ATTR_RESET : attr_reg;
        we = 1'b0;
        wa = wb_addr_reg;
        wd = rd_data_reg;
        if (wb_pend_reg) begin
            we = 1'b1;
        end else if (cmd.blank_step) begin
            we = 1'b1;
            wa = sweep_reg;
            wd = {blank_attr, CHAR_BLANK};
        end else if (cmd.put_step && is_write) begin
            we = 1'b1;
            wa = pos_wide[AW-1:0];
            wd = {attr_reg, in_reg.char_code};
        end
        re = cmd.rd_issue || cmd.copy_step;
        ra = cmd.copy_step ? (sweep_reg + AW'(COLUMNS)) : idx_wide[AW-1:0];
    end

    always_comb begin
        out_next.cursor_position = pos_wide[POS_W-1:0];
        out_next.cell_char       = '0;
        out_next.cell_attribute  = '0;
        if ((command_t'(in_reg.command) == CMD_READ) && rd_ok_reg) begin
            out_next.cell_char      = rd_data_reg[7:0];
            out_next.cell_attribute = rd_data_reg[15:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            rd_data_reg <= mem[ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            sweep_reg   <= '0;
            wb_pend_reg <= 1'b0;
            attr_reg    <= ATTR_RESET;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            sweep_reg   <= sweep_next;
            wb_pend_reg <= cmd.copy_step;
            if (cfg_valid) begin
                attr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
        if (cmd.copy_step) begin
            wb_addr_reg <= sweep_reg;
        end
        if (cmd.rd_issue) begin
            rd_ok_reg <= idx_ok;
        end
        if (cmd.load_out) begin
            out_reg <= out_next;
        end
    end

    assign stat.op         = command_t'(in_reg.command);
    assign stat.put_scroll = line_feed && row_last;
    assign stat.sweep_last = (sweep_reg == AW'(CELLS - 1));
    assign stat.copy_last  = (sweep_reg == AW'(CELLS - COLUMNS - 1));
    assign m_data          = out_reg;

endmodule

// ===== src/tcw_ctrl.sv =====
// Controller of the text console writer: sequences commands, scroll and clear sweeps.
// Depends on tcw_pkg; drives tcw_datapath through tcw_cmd_t.
module tcw_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  tcw_pkg::tcw_stat_t stat,
    output tcw_pkg::tcw_cmd_t  cmd
);
    import tcw_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (stat.sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                unique case (stat.op)
                    CMD_PUT:   state_next = stat.put_scroll ? ST_COPY : ST_DONE;
                    CMD_CLEAR: state_next = ST_CLEAR;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_COPY: begin
                if (stat.copy_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_BLANK;
            ST_BLANK, ST_CLEAR: begin
                if (stat.sweep_last) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.blank_step       = 1'b1;
                cmd.blank_reset_attr = 1'b1;
            end
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_EXEC: begin
                unique case (stat.op)
                    CMD_PUT: begin
                        cmd.put_step   = 1'b1;
                        cmd.sweep_zero = stat.put_scroll;
                    end
                    CMD_CLEAR: begin
                        cmd.home       = 1'b1;
                        cmd.sweep_zero = 1'b1;
                    end
                    CMD_READ: cmd.rd_issue = 1'b1;
                    default: ;
                endcase
            end
            ST_COPY:  cmd.copy_step     = 1'b1;
            ST_DRAIN: cmd.sweep_lastrow = 1'b1;
            ST_BLANK, ST_CLEAR: cmd.blank_step = 1'b1;
            ST_DONE:  cmd.load_out      = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;

    // A held result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while held");

    // One item at a time: no second transfer right after an accepted one
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is in flight");

    // A put that runs off the bottom row always scrolls
    a_scroll_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.put_step && stat.put_scroll) |=> (state_reg == ST_COPY))
        else $error("bottom-row wrap did not start a scroll");

    // Store write-back of a scroll never collides with a blanking write
    a_wb_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.copy_step) |-> !cmd.blank_step)
        else $error("scroll write-back collides with blank write");

endmodule

// ===== tb/tb_text_console_writer.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for text_console_writer: queued command driver, result monitor,
// and a command-level model of the console screen, cursor and attribute register.
// Depends on tcw_pkg and the text_console_writer RTL.
module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int COLUMNS    = DEF_COLUMNS;
    localparam int ROWS       = DEF_ROWS;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int MAX_INDEX  = (1 << INDEX_W) - 1;
    localparam int CLK_PERIOD = 10;
    // Worst case: every item a clear or scroll (a sweep over the whole store) with long stalls on
    // both sides, plus the clearing pass after reset; then taken several times over.
    localparam int LIMIT_CYCLES = 10_000_000;
    localparam int RANDOM_PER_PHASE = 350;

    // Clock, reset and all block inputs start at known values.
    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    tcw_in_t    s_data  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    tcw_out_t   m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = '0;

    // Commands waiting to be driven, and console results waiting to come back.
    tcw_in_t  queued_commands[$];
    tcw_out_t expected_results[$];
    tcw_out_t oldest_result;

    // Idle percentages for the sender and the receiver, set per phase.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Console shadow: screen cells (attribute in the high byte), cursor and attribute.
    logic [15:0] screen_shadow [0:CELL_COUNT-1];
    int unsigned cur_col = 0;
    int unsigned cur_row = 0;
    logic [7:0]  text_attr = ATTR_RESET;

    int failures       = 0;
    int cycle_count    = 0;
    int puts_done      = 0;
    int reads_done     = 0;
    int clears_done    = 0;
    int scrolls_done   = 0;
    int results_seen   = 0;
    int attr_writes    = 0;

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Apply one command to the console shadow and return the result it produces.
    function automatic tcw_out_t console_step(input tcw_in_t item);
        tcw_out_t res;
        int unsigned i;
        res = '0;
        case (command_t'(item.command))
            CMD_PUT: begin
                puts_done++;
                if (item.char_code == CHAR_NEWLINE) begin
                    cur_col = 0;
                    cur_row++;
                end else if (item.char_code == CHAR_TAB) begin
                    // Tab stops short of the last column, else breaks the line.
                    if (cur_col + TAB_STEP < COLUMNS - 1) begin
                        cur_col += TAB_STEP;
                    end else begin
                        cur_col = 0;
                        cur_row++;
                    end
                end else begin
                    screen_shadow[cur_row * COLUMNS + cur_col] = {text_attr, item.char_code};
                    if (cur_col < COLUMNS - 1) begin
                        cur_col++;
                    end else begin
                        cur_col = 0;
                        cur_row++;
                    end
                end
                // Scroll up one row and blank the bottom row in the current attribute.
                if (cur_row >= ROWS) begin
                    scrolls_done++;
                    for (i = 0; i < CELL_COUNT - COLUMNS; i++)
                        screen_shadow[i] = screen_shadow[i + COLUMNS];
                    for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                        screen_shadow[i] = {text_attr, CHAR_BLANK};
                    cur_col = 0;
                    cur_row = ROWS - 1;
                end
            end
            CMD_CLEAR: begin
                clears_done++;
                for (i = 0; i < CELL_COUNT; i++)
                    screen_shadow[i] = {text_attr, CHAR_BLANK};
                cur_col = 0;
                cur_row = 0;
            end
            CMD_READ: begin
                reads_done++;
                // Out-of-range cells read as zero.
                if (item.cell_index < CELL_COUNT) begin
                    res.cell_char      = screen_shadow[item.cell_index][7:0];
                    res.cell_attribute = screen_shadow[item.cell_index][15:8];
                end
            end
            default: ;
        endcase
        res.cursor_position = POS_W'(cur_row * COLUMNS + cur_col);
        return res;
    endfunction

    function automatic tcw_in_t make_command(input command_t op, input logic [7:0] ch,
                                             input logic [INDEX_W-1:0] idx);
        tcw_in_t item;
        item.command    = op;
        item.char_code  = ch;
        item.cell_index = idx;
        return item;
    endfunction

    // Favor the bottom rows where text lands, but cover the whole index range.
    function automatic logic [INDEX_W-1:0] pick_cell_index();
        int sel;
        sel = $urandom_range(99);
        if (sel < 35)
            return INDEX_W'($urandom_range(CELL_COUNT - 1, CELL_COUNT - 2 * COLUMNS));
        else if (sel < 70)
            return INDEX_W'($urandom_range(CELL_COUNT - 1, 0));
        else if (sel < 88)
            return INDEX_W'($urandom_range(MAX_INDEX, CELL_COUNT));
        else if (sel < 92)
            return INDEX_W'(0);
        else if (sel < 96)
            return INDEX_W'(CELL_COUNT - 1);
        return INDEX_W'(MAX_INDEX);
    endfunction

    // Driver: predict on each transfer, then hold, load the next command or idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(console_step(s_data));
            end
            if (!s_valid || s_ready) begin
                if (queued_commands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data  <= queued_commands.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transfer with the oldest expected result.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected result pos=%0d char=%02h attr=%02h", $time,
                             m_data.cursor_position, m_data.cell_char, m_data.cell_attribute);
                end else begin
                    oldest_result = expected_results.pop_front();
                    if (m_data.cursor_position !== oldest_result.cursor_position ||
                        m_data.cell_char !== oldest_result.cell_char ||
                        m_data.cell_attribute !== oldest_result.cell_attribute) begin
                        failures++;
                        $display("%0t: mismatch expected pos=%0d char=%02h attr=%02h, got pos=%0d char=%02h attr=%02h",
                                 $time, oldest_result.cursor_position, oldest_result.cell_char,
                                 oldest_result.cell_attribute, m_data.cursor_position,
                                 m_data.cell_char, m_data.cell_attribute);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // Write the attribute register; only called while the console is idle.
    task automatic write_attribute(input logic [7:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        text_attr = value;
        attr_writes++;
    endtask

    // Hold until every queued command is transferred and every result has returned.
    task automatic wait_until_drained();
        do @(negedge aclk);
        while (queued_commands.size() != 0 || s_valid || expected_results.size() != 0);
    endtask

    // Random traffic as well-formed runs: text, line breaks, tab runs, reads, plus noise.
    task automatic queue_random_traffic(input int target);
        int made;
        int kind;
        int run;
        int k;
        made = 0;
        while (made < target) begin
            kind = $urandom_range(99);
            if (kind < 42) begin
                run = $urandom_range(30, 1);
                for (k = 0; k < run; k++)
                    queued_commands.push_back(make_command(CMD_PUT, 8'($urandom_range(255)),
                                                           INDEX_W'($urandom)));
            end else if (kind < 54) begin
                run = $urandom_range(6, 1);
                for (k = 0; k < run; k++)
                    queued_commands.push_back(make_command(CMD_PUT, CHAR_NEWLINE,
                                                           INDEX_W'($urandom)));
            end else if (kind < 62) begin
                // Long tab runs reach the right edge and break the line.
                run = $urandom_range(22, 1);
                for (k = 0; k < run; k++)
                    queued_commands.push_back(make_command(CMD_PUT, CHAR_TAB,
                                                           INDEX_W'($urandom)));
            end else if (kind < 89) begin
                run = $urandom_range(4, 1);
                for (k = 0; k < run; k++)
                    queued_commands.push_back(make_command(CMD_READ, 8'($urandom),
                                                           pick_cell_index()));
            end else if (kind < 91) begin
                run = 1;
                queued_commands.push_back(make_command(CMD_CLEAR, 8'($urandom),
                                                       INDEX_W'($urandom)));
            end else if (kind < 94) begin
                // Unused command changes nothing; not counted as traffic.
                run = 0;
                queued_commands.push_back(make_command(CMD_NONE, 8'($urandom),
                                                       INDEX_W'($urandom)));
            end else begin
                run = 1;
                queued_commands.push_back(make_command(command_t'($urandom_range(3)),
                                                       8'($urandom), INDEX_W'($urandom)));
            end
            made += run;
        end
    endtask

    initial begin
        for (int i = 0; i < CELL_COUNT; i++)
            screen_shadow[i] = {ATTR_RESET, CHAR_BLANK};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset attribute: sender mostly busy, receiver mostly stalled.
        send_idle_pct = 6;
        recv_idle_pct = 71;
        queued_commands.push_back(make_command(CMD_READ, 8'h00, INDEX_W'(0)));
        queued_commands.push_back(make_command(CMD_READ, 8'hFF, INDEX_W'(MAX_INDEX)));
        queued_commands.push_back(make_command(CMD_READ, 8'h00, INDEX_W'(CELL_COUNT)));
        queued_commands.push_back(make_command(CMD_READ, 8'h00, INDEX_W'(CELL_COUNT - 1)));
        queued_commands.push_back(make_command(CMD_PUT, 8'h00, INDEX_W'(MAX_INDEX)));
        queued_commands.push_back(make_command(CMD_PUT, 8'hFF, INDEX_W'(0)));
        queued_commands.push_back(make_command(CMD_PUT, CHAR_TAB, INDEX_W'(0)));
        queued_commands.push_back(make_command(CMD_PUT, 8'h41, INDEX_W'(0)));
        queued_commands.push_back(make_command(CMD_NONE, 8'hFF, INDEX_W'(MAX_INDEX)));
        queued_commands.push_back(make_command(CMD_READ, 8'h00, INDEX_W'(0)));
        queued_commands.push_back(make_command(CMD_READ, 8'h00, INDEX_W'(1)));
        queued_commands.push_back(make_command(CMD_READ, 8'h00, INDEX_W'(6)));
        queued_commands.push_back(make_command(CMD_PUT, CHAR_NEWLINE, INDEX_W'(0)));
        queued_commands.push_back(make_command(CMD_PUT, CHAR_TAB, INDEX_W'(0)));
        queued_commands.push_back(make_command(CMD_PUT, 8'h7A, INDEX_W'(0)));
        queued_commands.push_back(make_command(CMD_READ, 8'h00, INDEX_W'(COLUMNS + 4)));
        queued_commands.push_back(make_command(CMD_CLEAR, 8'hFF, INDEX_W'(MAX_INDEX)));
        queued_commands.push_back(make_command(CMD_READ, 8'h00, INDEX_W'(0)));
        queued_commands.push_back(make_command(CMD_READ, 8'h00, INDEX_W'(COLUMNS + 4)));
        queued_commands.push_back(make_command(CMD_PUT, 8'h7F, INDEX_W'(0)));
        queued_commands.push_back(make_command(CMD_NONE, 8'h00, INDEX_W'(0)));
        wait_until_drained();

        // Random phases: attribute at both extremes, then a mid value; idling swapped, then off.
        write_attribute(8'hFF);
        queue_random_traffic(RANDOM_PER_PHASE);
        wait_until_drained();

        send_idle_pct = 71;
        recv_idle_pct = 6;
        write_attribute(8'h00);
        queue_random_traffic(RANDOM_PER_PHASE);
        wait_until_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_attribute(8'($urandom_range(254, 1)));
        queue_random_traffic(RANDOM_PER_PHASE);
        wait_until_drained();

        // Let any stray result show up before the verdict.
        repeat (20) @(posedge aclk);

        $display("Covered %0d results: %0d puts with %0d scrolls, %0d reads, %0d clears",
                 results_seen, puts_done, scrolls_done, reads_done, clears_done);
        $display("Attribute register written %0d times; %0d mismatches", attr_writes,
                 failures);
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/tcw_pkg.sv
src/tcw_datapath.sv
src/tcw_ctrl.sv
src/text_console_writer.sv
tb/tb_text_console_writer.sv
